@@ sv/wlsm_pkg.sv @@
`timescale 1ns / 1ps
// Package of the write latency statistics monitor: statistic codes, divider
// operand selection and the command and status structs between controller
// and datapath. Depends on nothing.
package wlsm_pkg;

  // Order in which a report delivers the statistics.
  typedef enum logic [3:0] {
    STAT_CALLS      = 4'd0,
    STAT_REQUESTED  = 4'd1,
    STAT_WRITTEN    = 4'd2,
    STAT_TIMEOUTS   = 4'd3,
    STAT_ERRORS     = 4'd4,
    STAT_SHORT      = 4'd5,
    STAT_ZERO       = 4'd6,
    STAT_AVG        = 4'd7,
    STAT_MAX_DUR    = 4'd8,
    STAT_MAX_AT_MS  = 4'd9,
    STAT_START_GAP  = 4'd10,
    STAT_IDLE_GAP   = 4'd11,
    STAT_IDLE_AT_MS = 4'd12
  } stat_idx_e;

  localparam stat_idx_e STAT_LAST = STAT_IDLE_AT_MS;

  // Microseconds per millisecond.
  localparam logic [31:0] US_PER_MS = 32'd1000;

  // Reciprocal of 1000 scaled by 2^28 and rounded up. Multiplying by it and
  // keeping bits 28 and up gives x / 1000 exactly for every x below 2^18.
  localparam logic [18:0] MS_RECIP = 19'd268436;

  // Operand set of the current division.
  typedef enum logic [1:0] {
    DIV_AVG = 2'd0,
    DIV_MS1 = 2'd1,
    DIV_MS2 = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic      rec_cap;    // capture a record item and form its differences
    logic      acc;        // fold the captured record into the statistics
    logic      div_start;  // launch the divider
    div_sel_e  div_sel;    // operands of the current division
    logic      quo_load;   // store the finished quotient
    logic      emit;       // load one statistic into the output register
    stat_idx_e emit_idx;   // which statistic
    logic      clear;      // clear all statistics
  } cmd_t;

  typedef struct packed {
    logic div_done;        // quotient ready this cycle
    logic out_free;        // output register can take a new item
  } sts_t;

endpackage

@@ sv/wlsm_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels of the write latency statistics monitor: the record
// channel and the statistic channel. No dependencies.
interface wlsm_rec_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] frames_requested;
  logic [31:0] frames_written;
  logic        timed_out;
  logic        failed;
  logic [47:0] start_time;
  logic [47:0] finish_time;
  logic [47:0] prior_start_time;
  logic [47:0] prior_finish_time;

  modport source (
    output valid, op, frames_requested, frames_written, timed_out, failed,
           start_time, finish_time, prior_start_time, prior_finish_time,
    input  ready
  );
  modport sink (
    input  valid, op, frames_requested, frames_written, timed_out, failed,
           start_time, finish_time, prior_start_time, prior_finish_time,
    output ready
  );
endinterface

interface wlsm_stat_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  stat_index;
  logic signed [63:0] stat_value;
  logic               last_stat;

  modport source (
    output valid, stat_index, stat_value, last_stat,
    input  ready
  );
  modport sink (
    input  valid, stat_index, stat_value, last_stat,
    output ready
  );
endinterface

@@ sv/wlsm_div.sv @@
`timescale 1ns / 1ps
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle. Standalone; used by the datapath.
module wlsm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] dsr_q;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // The dividend shifts out of the top of quo_q while quotient bits enter
  // at the bottom.
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

@@ sv/wlsm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the write latency statistics monitor: statistics registers,
// record arithmetic, dividers and output register. Uses wlsm_pkg, wlsm_div.
module wlsm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wlsm_pkg::cmd_t      cmd_i,
  output wlsm_pkg::sts_t      sts_o,
  input  logic [31:0]         frames_requested_i,
  input  logic [31:0]         frames_written_i,
  input  logic                timed_out_i,
  input  logic                failed_i,
  input  logic [47:0]         start_time_i,
  input  logic [47:0]         finish_time_i,
  input  logic [47:0]         prior_start_time_i,
  input  logic [47:0]         prior_finish_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          out_index_o,
  output logic signed [63:0]  out_value_o,
  output logic                out_last_o
);

  // Captured record; differences are 49-bit signed.
  logic [31:0] req_q, wr_q;
  logic        to_q, fail_q, short_q, zero_q;
  logic [47:0] st_q;
  logic [48:0] dur_q, sgap_q, igap_q;
  logic        sgap_ok_q, igap_ok_q;

  // Statistics.
  logic [31:0] calls_q, reqtot_q, wrtot_q, tocnt_q, errcnt_q, shortcnt_q, zerocnt_q;
  logic [63:0] dsum_q;
  logic [47:0] max_dur_q, max_dur_at_q, max_sgap_q, max_igap_q, max_igap_at_q;

  // Report quotients.
  logic [63:0] avg_q;
  logic [38:0] ms1_q, ms2_q;

  // Output register.
  logic        out_valid_q;
  logic [3:0]  out_index_q;
  logic [63:0] out_value_q;
  logic        out_last_q;

  // Millisecond conversion.
  logic        ms_busy_q, ms_done_q;
  logic [2:0]  ms_cnt_q;
  logic [9:0]  ms_rem_q;
  logic [47:0] ms_src_q;
  logic [47:0] ms_quo_q;
  logic [47:0] ms_dvd;
  logic [17:0] ms_x;
  logic [35:0] ms_prod;
  logic [7:0]  ms_digit;
  logic [17:0] ms_left;

  logic [63:0] sum_mag;
  logic        avg_start, ms_start;
  logic        div_done;
  logic [63:0] div_quo;
  logic [63:0] sel_value;
  logic        dur_new, sgap_new, igap_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_cap) begin
      req_q     <= frames_requested_i;
      wr_q      <= frames_written_i;
      to_q      <= timed_out_i;
      fail_q    <= failed_i;
      short_q   <= frames_written_i < frames_requested_i;
      zero_q    <= frames_written_i == 32'd0;
      st_q      <= start_time_i;
      dur_q     <= {1'b0, finish_time_i} - {1'b0, start_time_i};
      sgap_q    <= {1'b0, start_time_i} - {1'b0, prior_start_time_i};
      igap_q    <= {1'b0, start_time_i} - {1'b0, prior_finish_time_i};
      sgap_ok_q <= prior_start_time_i != 48'd0;
      igap_ok_q <= prior_finish_time_i != 48'd0;
    end
  end

  // A maximum starts at zero, so only a nonnegative, strictly larger value wins.
  assign dur_new  = !dur_q[48] && (dur_q[47:0] > max_dur_q);
  assign sgap_new = sgap_ok_q && !sgap_q[48] && (sgap_q[47:0] > max_sgap_q);
  assign igap_new = igap_ok_q && !igap_q[48] && (igap_q[47:0] > max_igap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calls_q       <= '0;
      reqtot_q      <= '0;
      wrtot_q       <= '0;
      tocnt_q       <= '0;
      errcnt_q      <= '0;
      shortcnt_q    <= '0;
      zerocnt_q     <= '0;
      dsum_q        <= '0;
      max_dur_q     <= '0;
      max_dur_at_q  <= '0;
      max_sgap_q    <= '0;
      max_igap_q    <= '0;
      max_igap_at_q <= '0;
    end else if (cmd_i.clear) begin
      calls_q       <= '0;
      reqtot_q      <= '0;
      wrtot_q       <= '0;
      tocnt_q       <= '0;
      errcnt_q      <= '0;
      shortcnt_q    <= '0;
      zerocnt_q     <= '0;
      dsum_q        <= '0;
      max_dur_q     <= '0;
      max_dur_at_q  <= '0;
      max_sgap_q    <= '0;
      max_igap_q    <= '0;
      max_igap_at_q <= '0;
    end else if (cmd_i.acc) begin
      calls_q    <= calls_q + 32'd1;
      reqtot_q   <= reqtot_q + req_q;
      wrtot_q    <= wrtot_q + wr_q;
      tocnt_q    <= tocnt_q + {31'd0, to_q};
      errcnt_q   <= errcnt_q + {31'd0, fail_q};
      shortcnt_q <= shortcnt_q + {31'd0, short_q};
      zerocnt_q  <= zerocnt_q + {31'd0, zero_q};
      dsum_q     <= dsum_q + {{15{dur_q[48]}}, dur_q};
      if (dur_new) begin
        max_dur_q    <= dur_q[47:0];
        max_dur_at_q <= st_q;
      end
      if (sgap_new) begin
        max_sgap_q <= sgap_q[47:0];
      end
      if (igap_new) begin
        max_igap_q    <= igap_q[47:0];
        max_igap_at_q <= st_q;
      end
    end
  end

  // Average divides the magnitude and restores the sign afterwards.
  assign sum_mag = dsum_q[63] ? (~dsum_q + 64'd1) : dsum_q;

  assign avg_start = cmd_i.div_start && (cmd_i.div_sel == wlsm_pkg::DIV_AVG);
  assign ms_start  = cmd_i.div_start && (cmd_i.div_sel != wlsm_pkg::DIV_AVG);

  wlsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (avg_start),
    .dividend_i (sum_mag),
    .divisor_i  (calls_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    case (cmd_i.div_sel)
      wlsm_pkg::DIV_MS1: ms_dvd = max_dur_at_q;
      wlsm_pkg::DIV_MS2: ms_dvd = max_igap_at_q;
      default:           ms_dvd = '0;
    endcase
  end

  // Long division by 1000, one byte of the time per cycle.
  // The remainder stays below 1000, so each partial dividend is below 2^18
  // and its quotient byte comes from the reciprocal multiplication.
  assign ms_x     = {ms_rem_q, ms_src_q[47:40]};
  assign ms_prod  = 36'(ms_x) * 36'(wlsm_pkg::MS_RECIP);
  assign ms_digit = ms_prod[35:28];
  assign ms_left  = ms_x - 18'(ms_digit) * 18'(wlsm_pkg::US_PER_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_busy_q <= 1'b0;
      ms_done_q <= 1'b0;
      ms_cnt_q  <= '0;
    end else begin
      ms_done_q <= 1'b0;
      if (ms_start) begin
        ms_busy_q <= 1'b1;
        ms_cnt_q  <= 3'd5;
      end else if (ms_busy_q) begin
        ms_cnt_q <= ms_cnt_q - 3'd1;
        if (ms_cnt_q == 3'd0) begin
          ms_busy_q <= 1'b0;
          ms_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ms_start) begin
      ms_src_q <= ms_dvd;
      ms_rem_q <= '0;
    end else if (ms_busy_q) begin
      ms_src_q <= {ms_src_q[39:0], 8'd0};
      ms_rem_q <= ms_left[9:0];
      ms_quo_q <= {ms_quo_q[39:0], ms_digit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quo_load) begin
      case (cmd_i.div_sel)
        wlsm_pkg::DIV_AVG: begin
          if (calls_q == 32'd0) begin
            avg_q <= '0;
          end else begin
            avg_q <= dsum_q[63] ? (~div_quo + 64'd1) : div_quo;
          end
        end
        wlsm_pkg::DIV_MS1: ms1_q <= ms_quo_q[38:0];
        wlsm_pkg::DIV_MS2: ms2_q <= ms_quo_q[38:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.emit_idx)
      wlsm_pkg::STAT_CALLS:      sel_value = {32'd0, calls_q};
      wlsm_pkg::STAT_REQUESTED:  sel_value = {32'd0, reqtot_q};
      wlsm_pkg::STAT_WRITTEN:    sel_value = {32'd0, wrtot_q};
      wlsm_pkg::STAT_TIMEOUTS:   sel_value = {32'd0, tocnt_q};
      wlsm_pkg::STAT_ERRORS:     sel_value = {32'd0, errcnt_q};
      wlsm_pkg::STAT_SHORT:      sel_value = {32'd0, shortcnt_q};
      wlsm_pkg::STAT_ZERO:       sel_value = {32'd0, zerocnt_q};
      wlsm_pkg::STAT_AVG:        sel_value = avg_q;
      wlsm_pkg::STAT_MAX_DUR:    sel_value = {16'd0, max_dur_q};
      wlsm_pkg::STAT_MAX_AT_MS:  sel_value = {25'd0, ms1_q};
      wlsm_pkg::STAT_START_GAP:  sel_value = {16'd0, max_sgap_q};
      wlsm_pkg::STAT_IDLE_GAP:   sel_value = {16'd0, max_igap_q};
      wlsm_pkg::STAT_IDLE_AT_MS: sel_value = {25'd0, ms2_q};
      default:                   sel_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= cmd_i.emit_idx;
      out_value_q <= sel_value;
      out_last_q  <= cmd_i.emit_idx == wlsm_pkg::STAT_LAST;
    end
  end

  assign sts_o.div_done = div_done || ms_done_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_index_q == wlsm_pkg::STAT_LAST)
    else $error("last flag on a statistic other than the final one");

  a_max_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.acc && !cmd_i.clear) |=> $stable(max_dur_q) && $stable(calls_q))
    else $error("statistics changed without a record or a clear");

  a_ms_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_start |-> !ms_busy_q)
    else $error("millisecond conversion started while busy");

endmodule

@@ sv/wlsm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the write latency statistics monitor: accepts items and
// sequences record, division and report steps. Uses wlsm_pkg.
module wlsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  logic           rec_op_i,
  output logic           rec_ready_o,
  input  wlsm_pkg::sts_t sts_i,
  output wlsm_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_REC      = 9'b000000010,
    S_AVG_GO   = 9'b000000100,
    S_AVG_WAIT = 9'b000001000,
    S_MS1_GO   = 9'b000010000,
    S_MS1_WAIT = 9'b000100000,
    S_MS2_GO   = 9'b001000000,
    S_MS2_WAIT = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  wlsm_pkg::stat_idx_e idx_q, idx_d;

  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    rec_ready_o      = 1'b0;
    cmd_o            = '0;
    cmd_o.div_sel    = wlsm_pkg::DIV_AVG;
    cmd_o.emit_idx   = idx_q;
    case (state_q)
      S_IDLE: begin
        rec_ready_o = 1'b1;
        if (rec_valid_i) begin
          if (rec_op_i) begin
            state_d = S_AVG_GO;
          end else begin
            cmd_o.rec_cap = 1'b1;
            state_d       = S_REC;
          end
        end
      end
      S_REC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_IDLE;
      end
      S_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.quo_load = 1'b1;
          state_d        = S_MS1_GO;
        end
      end
      S_MS1_GO: begin
        cmd_o.div_sel   = wlsm_pkg::DIV_MS1;
        cmd_o.div_start = 1'b1;
        state_d         = S_MS1_WAIT;
      end
      S_MS1_WAIT: begin
        cmd_o.div_sel = wlsm_pkg::DIV_MS1;
        if (sts_i.div_done) begin
          cmd_o.quo_load = 1'b1;
          state_d        = S_MS2_GO;
        end
      end
      S_MS2_GO: begin
        cmd_o.div_sel   = wlsm_pkg::DIV_MS2;
        cmd_o.div_start = 1'b1;
        state_d         = S_MS2_WAIT;
      end
      S_MS2_WAIT: begin
        cmd_o.div_sel = wlsm_pkg::DIV_MS2;
        if (sts_i.div_done) begin
          cmd_o.quo_load = 1'b1;
          idx_d          = wlsm_pkg::STAT_CALLS;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == wlsm_pkg::STAT_LAST) begin
            // The final statistic is latched on the same edge that clears.
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            idx_d = wlsm_pkg::stat_idx_e'(idx_q + 4'd1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= wlsm_pkg::STAT_CALLS;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> idx_q <= wlsm_pkg::STAT_LAST)
    else $error("report index ran past the final statistic");

endmodule

@@ sv/write_latency_stats_monitor.sv @@
`timescale 1ns / 1ps
// Top level of the write latency statistics monitor. Uses wlsm_pkg, the
// channel interfaces in wlsm_if.sv, wlsm_ctrl and wlsm_datapath.

// The monitor takes one item at a time on rec_i. A record item (op = 0) is
// folded into the interval statistics in two steps: the first captures the
// item and forms the duration and the two gaps, the second updates the
// wrapping 32-bit counters, the signed 64-bit duration sum and the three
// maxima. A report item (op = 1) first divides the duration sum by the call
// count on a bit-serial divider, then turns the two "at" times from
// microseconds into milliseconds with a divider by 1000; every division has
// a state to start it and one to wait for and store its quotient. It then
// delivers 13 items on stat_o in stat_index order, the last one flagged by
// last_stat, one per cycle while the sink keeps ready high. A report
// therefore holds the input until its final item enters the output register.
// All statistics are cleared as the final item enters the output register,
// so the next input item can be taken while that item still waits on stat_o.
module write_latency_stats_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  wlsm_rec_if.sink    rec_i,
  wlsm_stat_if.source stat_o
);

  wlsm_pkg::cmd_t cmd;
  wlsm_pkg::sts_t sts;

  wlsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_i.valid),
    .rec_op_i    (rec_i.op),
    .rec_ready_o (rec_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wlsm_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .frames_requested_i  (rec_i.frames_requested),
    .frames_written_i    (rec_i.frames_written),
    .timed_out_i         (rec_i.timed_out),
    .failed_i            (rec_i.failed),
    .start_time_i        (rec_i.start_time),
    .finish_time_i       (rec_i.finish_time),
    .prior_start_time_i  (rec_i.prior_start_time),
    .prior_finish_time_i (rec_i.prior_finish_time),
    .out_valid_o         (stat_o.valid),
    .out_ready_i         (stat_o.ready),
    .out_index_o         (stat_o.stat_index),
    .out_value_o         (stat_o.stat_value),
    .out_last_o          (stat_o.last_stat)
  );

endmodule
